// File: rtl/pstc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstc_pkg
// Shared types and constants for the pressure trend chart.
// ----------------------------------------------------------------------------
package pstc_pkg;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam int HPA_W     = 11;
    localparam int PA_W      = 17;
    localparam int STEP_W    = 7;
    localparam int MOVE_W    = 8;

    localparam logic [PA_W-1:0] PA_MAX     = 17'd127999;
    // pa / 100 as (pa * HPA_RECIP) >> HPA_SHIFT, exact for pa up to PA_MAX
    localparam logic [17:0]     HPA_RECIP  = 18'd167773;
    localparam int              HPA_SHIFT  = 24;
    // d / 10 as (d * ROW_RECIP) >> ROW_SHIFT, exact for d up to 2047
    localparam logic [10:0]     ROW_RECIP  = 11'd1639;
    localparam int              ROW_SHIFT  = 14;

    typedef struct packed {
        cmd_t             cmd;
        logic [HPA_W-1:0] hpa;
        logic [3:0]       row_index;
    } item_t;

    typedef struct packed {
        logic        rising;
        logic [3:0]  mark_row;
        logic [3:0]  mark_col;
        logic [11:0] row_bits;
    } result_t;

endpackage

// File: rtl/pressure_trend_chart.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_trend_chart
// Trend bitmap of pressure samples with cursor, direction flag and row reads.
// Path: an accepted request beat is held in the input register, then moves to the result register.
// Throughput: one beat per cycle while rsp_stall does not hold the result; input register and result register.
// The chart update is a single pass from the staged item to the state.
// Reset: asynchronous, clears chart, cursor at bottom-left, trend rising.
// ----------------------------------------------------------------------------
module pressure_trend_chart
    import pstc_pkg::*;
#(
    parameter int ROWS = 10,
    parameter int COLS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  cmd,
    input  logic [16:0] pressure_pa,
    input  logic [3:0]  row_index,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        rising,
    output logic [3:0]  mark_row,
    output logic [3:0]  mark_col,
    output logic [11:0] row_bits
);

    logic    advance;
    logic    fire;
    logic    stg_valid;
    item_t   item;
    result_t result;
    result_t result_reg;
    logic    rsp_valid_reg;
    logic    rsp_valid_next;

    assign advance        = !rsp_valid_reg || !rsp_stall;
    assign fire           = stg_valid && advance;
    assign rsp_valid_next = advance ? stg_valid : rsp_valid_reg;

    pstc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .pressure_pa (pressure_pa),
        .row_index   (row_index),
        .advance     (advance),
        .stg_valid   (stg_valid),
        .item        (item)
    );

    pstc_chart #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_chart (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rising    = result_reg.rising;
    assign mark_row  = result_reg.mark_row;
    assign mark_col  = result_reg.mark_col;
    assign row_bits  = result_reg.row_bits;

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("stall raised with empty result register");

    a_accept_stages: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> stg_valid)
        else $error("accepted beat not staged");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid && !rsp_stall |=> rsp_valid)
        else $error("staged beat did not reach result register");

endmodule

// File: rtl/pstc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstc_in_stage
// Input register: clamps the pressure and converts it to hPa on capture.
// ----------------------------------------------------------------------------
module pstc_in_stage
    import pstc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  cmd,
    input  logic [16:0] pressure_pa,
    input  logic [3:0]  row_index,
    input  logic        advance,
    output logic        stg_valid,
    output item_t       item
);

    logic              stg_valid_reg;
    logic              stg_valid_next;
    item_t             item_reg;
    logic [PA_W-1:0]   pa_clamped;
    logic [PA_W+17:0]  hpa_prod;

    assign pa_clamped = (pressure_pa > PA_MAX) ? PA_MAX : pressure_pa;
    assign hpa_prod   = {18'd0, pa_clamped} * {17'd0, HPA_RECIP};

    assign req_stall      = stg_valid_reg && !advance;
    assign stg_valid_next = req_stall ? stg_valid_reg : req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            item_reg.cmd       <= cmd_t'(cmd);
            item_reg.hpa       <= hpa_prod[HPA_SHIFT +: HPA_W];
            item_reg.row_index <= row_index;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign item      = item_reg;

endmodule

// File: rtl/pstc_chart.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstc_chart
// Chart state and single-pass update: trend, cursor, scrolls, mark and read.
// ----------------------------------------------------------------------------
module pstc_chart
    import pstc_pkg::*;
#(
    parameter int ROWS = 10,
    parameter int COLS = 12
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    localparam int RIW = $clog2(ROWS);
    localparam int CIW = $clog2(COLS + 1);

    logic [COLS-1:0]  rows_reg [ROWS];
    logic [COLS-1:0]  rows_next [ROWS];
    logic [RIW-1:0]   cursor_row_reg;
    logic [RIW-1:0]   cursor_row_next;
    logic [CIW-1:0]   cursor_col_reg;
    logic [CIW-1:0]   cursor_col_next;
    logic [HPA_W-1:0] last_hpa_reg;
    logic [HPA_W-1:0] last_hpa_next;
    logic             trend_up_reg;
    logic             trend_up_next;

    logic [COLS-1:0]  rows_h [ROWS];
    logic [COLS-1:0]  rows_v [ROWS];
    logic             col_over;
    logic [CIW-1:0]   col_m;
    logic             trend_s;
    logic             first;
    logic [HPA_W-1:0] diff_abs;
    logic [21:0]      step_prod;
    logic [STEP_W-1:0] step;
    logic [MOVE_W-1:0] row_w;
    logic [MOVE_W-1:0] row_sum;
    logic             do_move;
    logic             scroll_dn;
    logic             scroll_up;
    logic [MOVE_W-1:0] shift_n;
    logic [MOVE_W-1:0] src;
    logic [RIW-1:0]   row_new;
    logic [COLS-1:0]  mark_bit;
    logic [RIW-1:0]   sel_row;
    logic             sel_ok;
    logic [COLS-1:0]  bits;
    logic [COLS+11:0] bits_wide;
    logic [RIW+3:0]   mrow_wide;
    logic [CIW+3:0]   mcol_wide;
    logic             is_sample;

    assign is_sample = (item.cmd == CMD_SAMPLE);
    assign diff_abs  = (item.hpa > last_hpa_reg) ? (item.hpa - last_hpa_reg)
                                                 : (last_hpa_reg - item.hpa);
    assign step_prod = {11'd0, diff_abs} * {11'd0, ROW_RECIP};
    assign step      = step_prod[ROW_SHIFT +: STEP_W];

    always_comb
    begin
        trend_s = trend_up_reg;
        if (item.hpa > last_hpa_reg)
        begin
            trend_s = 1'b1;
        end
        else if (item.hpa < last_hpa_reg)
        begin
            trend_s = 1'b0;
        end
    end

    // horizontal scroll when the cursor ran past the last column
    assign col_over = (cursor_col_reg > CIW'(COLS - 1));
    assign col_m    = col_over ? CIW'(COLS - 1) : cursor_col_reg;

    // vertical move and scroll
    assign first     = (last_hpa_reg == '0);
    assign do_move   = !first && (step != '0);
    assign row_w     = MOVE_W'(cursor_row_reg);
    assign row_sum   = row_w + MOVE_W'(step);
    assign scroll_dn = do_move && trend_s && (row_w < MOVE_W'(step));
    assign scroll_up = do_move && !trend_s && (row_sum > MOVE_W'(ROWS - 1));

    always_comb
    begin
        shift_n = '0;
        row_new = cursor_row_reg;
        if (do_move)
        begin
            if (trend_s)
            begin
                if (scroll_dn)
                begin
                    shift_n = MOVE_W'(step) - row_w;
                    row_new = '0;
                end
                else
                begin
                    row_new = RIW'(row_w - MOVE_W'(step));
                end
            end
            else
            begin
                if (scroll_up)
                begin
                    shift_n = row_sum - MOVE_W'(ROWS - 1);
                    row_new = RIW'(ROWS - 1);
                end
                else
                begin
                    row_new = RIW'(row_sum);
                end
            end
        end
    end

    assign mark_bit = {{(COLS-1){1'b0}}, 1'b1} << col_m;

    always_comb
    begin
        src = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            rows_h[i] = col_over ? (rows_reg[i] >> 1) : rows_reg[i];
        end
        for (int i = 0; i < ROWS; i++)
        begin
            rows_v[i] = rows_h[i];
            if (scroll_dn)
            begin
                src = MOVE_W'(i) - shift_n;
                rows_v[i] = (shift_n <= MOVE_W'(i)) ? rows_h[src[RIW-1:0]] : '0;
            end
            else if (scroll_up)
            begin
                src = MOVE_W'(i) + shift_n;
                rows_v[i] = (src < MOVE_W'(ROWS)) ? rows_h[src[RIW-1:0]] : '0;
            end
        end
    end

    always_comb
    begin
        rows_next       = rows_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        last_hpa_next   = last_hpa_reg;
        trend_up_next   = trend_up_reg;
        case (item.cmd)
            CMD_SAMPLE:
            begin
                for (int i = 0; i < ROWS; i++)
                begin
                    rows_next[i] = rows_v[i] | ((RIW'(i) == row_new) ? mark_bit : '0);
                end
                cursor_row_next = row_new;
                cursor_col_next = col_m + CIW'(1);
                last_hpa_next   = item.hpa;
                trend_up_next   = trend_s;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < ROWS; i++)
                begin
                    rows_next[i] = '0;
                end
                cursor_row_next = RIW'(ROWS - 1);
                cursor_col_next = '0;
                last_hpa_next   = '0;
            end
            default:
            begin
                rows_next = rows_reg;
            end
        endcase
    end

    // one read port: marked row on a sample, requested row on a read
    assign sel_row = is_sample ? row_new : item.row_index[RIW-1:0];
    assign sel_ok  = is_sample ||
                     ((item.cmd == CMD_READ) && ({1'b0, item.row_index} < 5'(ROWS)));
    assign bits    = sel_ok ? rows_next[sel_row] : '0;

    assign bits_wide = {12'd0, bits};
    assign mrow_wide = {4'd0, (is_sample ? row_new : {RIW{1'b0}})};
    assign mcol_wide = {4'd0, (is_sample ? col_m : {CIW{1'b0}})};

    assign result.rising   = trend_up_next;
    assign result.mark_row = mrow_wide[3:0];
    assign result.mark_col = mcol_wide[3:0];
    assign result.row_bits = bits_wide[11:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                rows_reg[i] <= '0;
            end
            cursor_row_reg <= RIW'(ROWS - 1);
            cursor_col_reg <= '0;
            last_hpa_reg   <= '0;
            trend_up_reg   <= 1'b1;
        end
        else if (fire)
        begin
            rows_reg       <= rows_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            last_hpa_reg   <= last_hpa_next;
            trend_up_reg   <= trend_up_next;
        end
    end

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_row_reg <= RIW'(ROWS - 1))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_col_reg <= CIW'(COLS))
        else $error("cursor column out of range");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.cmd == CMD_CLEAR) |=>
            (cursor_row_reg == RIW'(ROWS - 1)) && (cursor_col_reg == '0) &&
            (last_hpa_reg == '0))
        else $error("clear did not reset cursor");

endmodule
